### design/acs_pkg.sv
// shared constants and types for the accumulator cpu step block
// no dependencies; imported by every module of the block
package acs_pkg;

    // store depths, both powers of two
    localparam int PROG_DEPTH = 256;
    localparam int DATA_DEPTH = 16;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int DATA_AW    = $clog2(DATA_DEPTH);

    // program word: opcode over operand
    localparam int WORD_W = 12;

    // request kinds carried on s_tuser
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // opcodes
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_STORE = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_IN    = 4'd5;
    localparam logic [3:0] OP_OUT   = 4'd6;
    localparam logic [3:0] OP_END   = 4'd7;
    localparam logic [3:0] OP_JMP   = 4'd8;
    localparam logic [3:0] OP_SKIPZ = 4'd9;

    // program store write request
    typedef struct packed {
        logic                 en;
        logic [PROG_AW-1:0]   addr;
        logic [WORD_W-1:0]    word;
    } prog_wr_t;

    // one result beat, pc_now in the lowest bits
    typedef struct packed {
        logic [3:0]  executed_opcode;
        logic        halted;
        logic        in_taken;
        logic        out_valid;
        logic [31:0] acc_now;
        logic [7:0]  pc_now;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

### design/acs_prog_mem.sv
// program store: synchronous ram with per-entry valid bits and write forwarding
// depends on acs_pkg
module acs_prog_mem
    import acs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  prog_wr_t           wr,
    input  logic [PROG_AW-1:0] rd_addr,
    output logic [WORD_W-1:0]  rd_word
);

    logic [WORD_W-1:0]     mem [PROG_DEPTH];
    logic [PROG_DEPTH-1:0] valid_reg;
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  fwd_reg;
    logic [WORD_W-1:0]     fwd_word_reg;

    // ram write and registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.word;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_word_reg <= wr.word;
    end

    // valid bits and forwarding flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            fwd_reg      <= wr.en && (wr.addr == rd_addr);
        end
    end

    // a write to the address being fetched wins; unwritten entries read as zero
    assign rd_word = fwd_reg      ? fwd_word_reg :
                     rd_valid_reg ? rd_data_reg  : '0;

endmodule

### design/acs_core.sv
// execute unit: pc, accumulator, halt flag and data register file
// depends on acs_pkg; fed by acs_prog_mem
module acs_core
    import acs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               req_type,
    input  logic [31:0]        in_value,
    input  logic [WORD_W-1:0]  word,
    output logic [PROG_AW-1:0] pc_fetch,
    output result_t            res
);

    logic [PROG_AW-1:0] pc_reg, pc_next;
    logic [31:0]        acc_reg, acc_next;
    logic               halt_reg, halt_next;
    logic [31:0]        data_reg [DATA_DEPTH];

    logic [3:0]          op;
    logic [7:0]          opd;
    logic [DATA_AW+7:0]  opd_dext;
    logic [PROG_AW+7:0]  opd_pext;
    logic [PROG_AW+7:0]  pc_wide;
    logic [DATA_AW-1:0]  da;
    logic [31:0]         dval;
    logic                dwe;
    logic                out_v, taken;
    logic [3:0]          exop;

    // decode the fetched word
    assign op       = word[11:8];
    assign opd      = word[7:0];
    assign opd_dext = {{DATA_AW{1'b0}}, opd};
    assign opd_pext = {{PROG_AW{1'b0}}, opd};
    assign da       = opd_dext[DATA_AW-1:0];
    assign dval     = data_reg[da];

    // execute one step
    always_comb begin
        pc_next   = pc_reg;
        acc_next  = acc_reg;
        halt_next = halt_reg;
        dwe       = 1'b0;
        out_v     = 1'b0;
        taken     = 1'b0;
        exop      = 4'd0;
        if (accept && (req_type == REQ_STEP) && !halt_reg) begin
            pc_next = pc_reg + 1'b1;
            exop    = op;
            case (op)
                OP_LOAD:  acc_next = dval;
                OP_ADD:   acc_next = acc_reg + dval;
                OP_STORE: dwe = 1'b1;
                OP_SUB:   acc_next = acc_reg - dval;
                OP_IN: begin
                    acc_next = in_value;
                    taken    = 1'b1;
                end
                OP_OUT:   out_v = 1'b1;
                OP_END:   halt_next = 1'b1;
                OP_JMP:   pc_next = opd_pext[PROG_AW-1:0];
                OP_SKIPZ: begin
                    if (acc_reg == 32'd0) begin
                        pc_next = pc_reg + PROG_AW'(2);
                    end
                end
                default: ;
            endcase
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            halt_reg <= 1'b0;
            for (int i = 0; i < DATA_DEPTH; i++) begin
                data_reg[i] <= '0;
            end
        end else begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            halt_reg <= halt_next;
            if (dwe) begin
                data_reg[da] <= acc_reg;
            end
        end
    end

    // fetch the word for the counter as it stands after this cycle
    assign pc_fetch = pc_next;

    // result beat
    assign pc_wide             = {8'd0, pc_next};
    assign res.pc_now          = pc_wide[7:0];
    assign res.acc_now         = acc_next;
    assign res.out_valid       = out_v;
    assign res.in_taken        = taken;
    assign res.halted          = halt_next;
    assign res.executed_opcode = exop;

endmodule

### design/accumulator_cpu_step.sv
// top level of the accumulator cpu step block: stream ports and output skid buffer
// depends on acs_pkg, acs_prog_mem, acs_core
//
//  channel   | direction | payload                                   | handshake
//  s_        | in        | tuser req kind, tdata program word/value  | s_tvalid/s_tready
//  m_        | out       | tdata pc, acc, flags, executed opcode     | m_tvalid/m_tready
//
// one beat per cycle in while s_tready is high; each beat executes in the cycle
// it is taken, its result goes to the m_ register, or to the skid register while
// m_ stalls. program ram reads at the next pc, so a jump or skip needs no stall.
// reset clears pc, accumulator, halt flag, data file and program valid bits
// at once; no clearing pass. s_tready drops only while the skid register holds
// a beat, after two results wait on a stalled m_ side.
module accumulator_cpu_step
    import acs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] prog_index, [11:8] prog_opcode, [19:12] prog_operand,
    // [51:20] in_value, [55:52] zero
    input  logic [55:0] s_tdata,
    // [0] req_type
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] pc_now, [39:8] acc_now, [40] out_valid, [41] in_taken,
    // [42] halted, [46:43] executed_opcode, [47] zero
    output logic [47:0] m_tdata
);

    logic               accept;
    prog_wr_t           wr;
    logic [PROG_AW+7:0] idx_ext;
    logic [PROG_AW-1:0] pc_fetch;
    logic [WORD_W-1:0]  word;
    result_t            res;

    logic    m_valid_reg;
    result_t m_data_reg;
    logic    sk_valid_reg;
    result_t sk_data_reg;

    assign s_tready = !sk_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // program write request
    assign idx_ext = {{PROG_AW{1'b0}}, s_tdata[7:0]};
    assign wr.en   = accept && (s_tuser == REQ_WRITE);
    assign wr.addr = idx_ext[PROG_AW-1:0];
    assign wr.word = {s_tdata[11:8], s_tdata[19:12]};

    acs_prog_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_addr (pc_fetch),
        .rd_word (word)
    );

    acs_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .req_type (s_tuser),
        .in_value (s_tdata[51:20]),
        .word     (word),
        .pc_fetch (pc_fetch),
        .res      (res)
    );

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else if (m_tready || !m_valid_reg) begin
            m_valid_reg  <= sk_valid_reg || accept;
            sk_valid_reg <= 1'b0;
        end else if (accept) begin
            sk_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_valid_reg) begin
            m_data_reg <= sk_valid_reg ? sk_data_reg : res;
        end else if (accept) begin
            sk_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

### design/acs_checker.sv
// port-level checks for accumulator_cpu_step, bound to the top level
// depends on acs_pkg
module acs_checker
    import acs_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic seen_halt_reg;

    // remember a delivered beat that reported the halt flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_halt_reg <= 1'b0;
        end else if (m_tvalid && m_tready && m_tdata[42]) begin
            seen_halt_reg <= 1'b1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // nothing pending right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input backpressure only with a result waiting
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // halt is sticky across delivered beats
    a_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_halt_reg |-> m_tdata[42])
        else $error("halt flag cleared");

    // flags match the executed opcode
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[40] || (m_tdata[46:43] == OP_OUT))
                  && (!m_tdata[41] || (m_tdata[46:43] == OP_IN)))
        else $error("flag without its opcode");

endmodule

bind accumulator_cpu_step acs_checker u_acs_checker (.*);
